FILE: hw/rtl/nst_pkg.sv
// nst_pkg: shared field widths, operation and status codes, fsm states
// for the named semaphore table; no dependencies
package nst_pkg;

    localparam int OP_W     = 1;
    localparam int NAME_W   = 8;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;

    localparam int NAME_SPACE  = 2 ** NAME_W;
    localparam int COUNTER_TOP = 31;

    localparam logic [OP_W-1:0] OP_WAIT   = 1'b0;
    localparam logic [OP_W-1:0] OP_SIGNAL = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_REJECTED   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_RELEASED   = 3'd4,
        ST_WOKE       = 3'd5,
        ST_UNKNOWN    = 3'd6
    } nst_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WAKE
    } nst_state_t;

endpackage

FILE: hw/rtl/nst_if.sv
// nst_if: request and response channels (valid/ready plus payload)
// depends on nst_pkg
interface nst_req_if;
    import nst_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [NAME_W-1:0] name_tag;
    logic [PID_W-1:0]  caller_pid;

    modport source (output valid, operation, name_tag, caller_pid, input ready);
    modport sink (input valid, operation, name_tag, caller_pid, output ready);
endinterface

interface nst_rsp_if;
    import nst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    woken_pid;
    logic [INDEX_W-1:0]  entry_index;

    modport source (output valid, status, woken_pid, entry_index, input ready);
    modport sink (input valid, status, woken_pid, entry_index, output ready);
endinterface

FILE: hw/rtl/nst_ram.sv
// nst_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/named_semaphore_table_core.sv
// named_semaphore_table_core: counting semaphores addressed by name tag,
// each with a fifo of waiting process ids
// depends on nst_pkg, nst_if, nst_ram
//
// usage
// - req (sink): one word per P (operation 0) or V (operation 1) request,
//   carrying the semaphore name tag and the caller's process id
// - rsp (source): exactly one word per request with status, the woken
//   process id and the table slot used
// - the per-name entry (slot, counter, waiter count, queue head) lives in a
//   ram indexed by name tag; waiter ids live in a second ram indexed by
//   slot and queue position; both have a registered read port
// - the response word is loaded into the output register from the lookup
//   step, or from the wake step for a V that wakes a waiter (extra waiter ram read)
// - a new request is accepted only in the idle step, once the last one has left
//   the lookup (or wake) step; set by the read-modify-write of the entry ram
// - reset clears the name valid bits, the slot count and the output register;
//   rams need no clearing, a slot is written when it is created
// - a stalled rsp holds its word; the next request is still accepted and
//   waits in the lookup step (the wake step for a V that wakes a waiter)
//   until the output register frees up
module named_semaphore_table_core #(
    parameter int TABLE_SLOTS = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    nst_req_if.sink   req,
    nst_rsp_if.source rsp
);
    import nst_pkg::*;

    localparam int SLOT_W   = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;
    localparam int USED_W   = $clog2(TABLE_SLOTS + 1);
    localparam int Q_W      = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int PW       = CW + 1;
    localparam int CNT_W    = ($clog2(QUEUE_DEPTH) + 1) > 6 ? ($clog2(QUEUE_DEPTH) + 1) : 6;
    localparam int NAME_AW  = NAME_W;
    localparam int WQ_DEPTH = TABLE_SLOTS * (2 ** Q_W);
    localparam int WQ_AW    = WQ_DEPTH > 1 ? $clog2(WQ_DEPTH) : 1;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNTER_TOP);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cnt;
        logic [CW-1:0]     count;
        logic [Q_W-1:0]    head;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    nst_state_t state_reg, state_next;

    logic [OP_W-1:0]       op_reg;
    logic [NAME_W-1:0]     tag_reg;
    logic [PID_W-1:0]      pid_reg;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [NAME_SPACE-1:0] valid_reg, valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PID_W-1:0]      woken_reg, woken_next;
    logic [INDEX_W-1:0]    index_reg, index_next;

    logic                  accept;
    logic                  out_free;
    logic                  emit;

    logic                  ent_we;
    entry_t                ent_wdata;
    logic [ENT_W-1:0]      ent_rdata;
    entry_t                ent;

    logic                  wq_we;
    logic [WQ_AW-1:0]      wq_waddr;
    logic                  wq_re;
    logic [WQ_AW-1:0]      wq_raddr;
    logic [PID_W-1:0]      wq_rdata;

    logic                  found;
    logic                  table_full;
    logic [SLOT_W-1:0]     cur_slot;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CW-1:0]         cur_count;
    logic [Q_W-1:0]        cur_head;
    logic                  cnt_positive;
    logic                  queue_full;
    logic [PW-1:0]         tail_sum;
    logic [PW-1:0]         tail_pos;
    logic [PW-1:0]         head_inc;
    logic [Q_W-1:0]        head_wrap;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign ent      = entry_t'(ent_rdata);

    nst_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NAME_SPACE)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (NAME_AW'(tag_reg)),
        .wdata (ENT_W'(ent_wdata)),
        .re    (accept),
        .raddr (NAME_AW'(req.name_tag)),
        .rdata (ent_rdata)
    );

    nst_ram #(
        .WIDTH(PID_W),
        .DEPTH(WQ_DEPTH)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (pid_reg),
        .re    (wq_re),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

    // entry view in the lookup step, a fresh slot when the name is new
    always_comb
    begin
        found      = valid_reg[tag_reg];
        table_full = !found && (used_reg == USED_W'(TABLE_SLOTS));
        if (found)
        begin
            cur_slot  = ent.slot;
            cur_cnt   = ent.cnt;
            cur_count = ent.count;
            cur_head  = ent.head;
        end
        else
        begin
            cur_slot  = SLOT_W'(used_reg);
            cur_cnt   = CNT_ONE;
            cur_count = '0;
            cur_head  = '0;
        end
        cnt_positive = !cur_cnt[CNT_W-1] && (cur_cnt != '0);
        queue_full   = (cur_count == CW'(QUEUE_DEPTH));
        tail_sum     = PW'(cur_head) + PW'(cur_count);
        tail_pos     = (tail_sum >= PW'(QUEUE_DEPTH)) ? tail_sum - PW'(QUEUE_DEPTH) : tail_sum;
        head_inc     = PW'(cur_head) + PW'(1);
        head_wrap    = (head_inc == PW'(QUEUE_DEPTH)) ? '0 : Q_W'(head_inc);
        wq_waddr     = WQ_AW'({cur_slot, Q_W'(tail_pos)});
        wq_raddr     = WQ_AW'({cur_slot, cur_head});
    end

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        used_next   = used_reg;
        valid_next  = valid_reg;
        emit        = 1'b0;
        status_next = status_reg;
        woken_next  = woken_reg;
        index_next  = index_reg;
        ent_we      = 1'b0;
        ent_wdata   = '{slot: cur_slot, cnt: cur_cnt, count: cur_count, head: cur_head};
        wq_we       = 1'b0;
        wq_re       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                slot_next = cur_slot;
                if (op_reg == OP_SIGNAL && found && cur_count != '0)
                begin
                    // release and wake the oldest waiter
                    ent_we          = 1'b1;
                    ent_wdata.cnt   = (cur_cnt != CNT_TOP) ? cur_cnt + CNT_ONE : cur_cnt;
                    ent_wdata.count = cur_count - CW'(1);
                    ent_wdata.head  = head_wrap;
                    wq_re           = 1'b1;
                    state_next      = S_WAKE;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    woken_next  = '0;
                    index_next  = INDEX_W'(cur_slot);
                    state_next  = S_IDLE;
                    if (op_reg == OP_WAIT)
                    begin
                        if (table_full)
                        begin
                            status_next = ST_TABLE_FULL;
                            index_next  = '0;
                        end
                        else
                        begin
                            if (!found)
                            begin
                                valid_next[tag_reg] = 1'b1;
                                used_next           = used_reg + USED_W'(1);
                            end
                            if (cnt_positive)
                            begin
                                status_next   = ST_ACQUIRED;
                                ent_we        = 1'b1;
                                ent_wdata.cnt = cur_cnt - CNT_ONE;
                            end
                            else if (queue_full)
                            begin
                                status_next = ST_REJECTED;
                            end
                            else
                            begin
                                status_next     = ST_QUEUED;
                                ent_we          = 1'b1;
                                ent_wdata.cnt   = cur_cnt - CNT_ONE;
                                ent_wdata.count = cur_count + CW'(1);
                                wq_we           = 1'b1;
                            end
                        end
                    end
                    else if (!found)
                    begin
                        status_next = ST_UNKNOWN;
                        index_next  = '0;
                    end
                    else
                    begin
                        status_next   = ST_RELEASED;
                        ent_we        = 1'b1;
                        ent_wdata.cnt = (cur_cnt != CNT_TOP) ? cur_cnt + CNT_ONE : cur_cnt;
                    end
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    status_next = ST_WOKE;
                    woken_next  = wq_rdata;
                    index_next  = INDEX_W'(slot_reg);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            tag_reg <= req.name_tag;
            pid_reg <= req.caller_pid;
        end
        slot_reg   <= slot_next;
        status_reg <= status_next;
        woken_reg  <= woken_next;
        index_reg  <= index_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.woken_pid   = woken_reg;
    assign rsp.entry_index = index_reg;

endmodule
